FILE: src/stable_matching_checker_defines.svh
// ----------------------------------------------------------------------------
// Stable matching checker assertion macros
// Shorthand for the concurrent checks that sit at the end of the RTL module.
// ----------------------------------------------------------------------------
`ifndef STABLE_MATCHING_CHECKER_DEFINES_SVH
`define STABLE_MATCHING_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/smc_pkg.sv
// ----------------------------------------------------------------------------
// Stable matching checker package
// Field widths, operation and validity codes, and the sequencer microcode.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int OP_W      = 2;
  localparam int ROW_W     = 4;
  localparam int POS_W     = 4;
  localparam int ENT_W     = 5;
  localparam int VAL_W     = 2;
  localparam int PCNT_MAX  = 31;

  localparam logic [ENT_W-1:0] N_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_HLIST = 2'd0,
    OP_SLIST = 2'd1,
    OP_PAIR  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [VAL_W-1:0] {
    VAL_OK       = 2'd0,
    VAL_COUNT    = 2'd1,
    VAL_HOSP_DUP = 2'd2,
    VAL_STUD_DUP = 2'd3
  } validity_t;

  // Microprogram steps.
  typedef enum logic [3:0] {
    UP_IDLE     = 4'd0,
    UP_PAIR_RD  = 4'd1,
    UP_PAIR_WR  = 4'd2,
    UP_CHK_INIT = 4'd3,
    UP_HP_RD    = 4'd4,
    UP_HL_RD    = 4'd5,
    UP_ST_RD    = 4'd6,
    UP_RK_RD    = 4'd7,
    UP_EVAL     = 4'd8,
    UP_NEXT_P   = 4'd9,
    UP_NEXT_H   = 4'd10,
    UP_EMIT     = 4'd11
  } upc_t;

  // Branch conditions the sequencer can test.
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_DISPATCH  = 3'd1,
    C_ST_EQ_CUR = 3'd2,
    C_ST_BAD    = 3'd3,
    C_ACCEPT    = 3'd4,
    C_P_MORE    = 3'd5,
    C_H_MORE    = 3'd6,
    C_OUT_BUSY  = 3'd7
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  in_rdy;
    logic  pair_rd;
    logic  pair_wr;
    logic  chk_init;
    logic  hp_rd;
    logic  hl_rd;
    logic  st_ld;
    logic  rk_rd;
    logic  mark_found;
    logic  p_inc;
    logic  h_inc;
    logic  emit;
    cond_t cond;
    upc_t  go_true;
    upc_t  go_false;
  } ctrl_t;

  // Read-only control store.
  function automatic ctrl_t ucode(input upc_t step);
    ctrl_t w;
    w          = '0;
    w.cond     = C_ALWAYS;
    w.go_true  = UP_IDLE;
    w.go_false = UP_IDLE;
    unique case (step)
      UP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_DISPATCH;
      end
      UP_PAIR_RD: begin
        w.pair_rd = 1'b1;
        w.go_true = UP_PAIR_WR;
      end
      UP_PAIR_WR: begin
        w.pair_wr = 1'b1;
        w.go_true = UP_IDLE;
      end
      UP_CHK_INIT: begin
        w.chk_init = 1'b1;
        w.go_true  = UP_HP_RD;
      end
      UP_HP_RD: begin
        w.hp_rd   = 1'b1;
        w.go_true = UP_HL_RD;
      end
      UP_HL_RD: begin
        w.hl_rd   = 1'b1;
        w.go_true = UP_ST_RD;
      end
      UP_ST_RD: begin
        w.st_ld    = 1'b1;
        w.cond     = C_ST_EQ_CUR;
        w.go_true  = UP_NEXT_H;
        w.go_false = UP_RK_RD;
      end
      UP_RK_RD: begin
        w.rk_rd    = 1'b1;
        w.cond     = C_ST_BAD;
        w.go_true  = UP_NEXT_P;
        w.go_false = UP_EVAL;
      end
      UP_EVAL: begin
        w.mark_found = 1'b1;
        w.cond       = C_ACCEPT;
        w.go_true    = UP_EMIT;
        w.go_false   = UP_NEXT_P;
      end
      UP_NEXT_P: begin
        w.p_inc    = 1'b1;
        w.cond     = C_P_MORE;
        w.go_true  = UP_HL_RD;
        w.go_false = UP_NEXT_H;
      end
      UP_NEXT_H: begin
        w.h_inc    = 1'b1;
        w.cond     = C_H_MORE;
        w.go_true  = UP_HP_RD;
        w.go_false = UP_EMIT;
      end
      UP_EMIT: begin
        w.emit     = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.go_true  = UP_EMIT;
        w.go_false = UP_IDLE;
      end
      default: begin
        w.go_true = UP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/stable_matching_checker.sv
// ----------------------------------------------------------------------------
// Stable matching checker
// Loads preference lists and matched pairs, then reports validity and the
// first blocking pair of the loaded matching on request.
// ----------------------------------------------------------------------------
// Each input word is one of four operations. A hospital list entry or a
// student list entry is written into its table in the cycle it is
// accepted. A matched pair goes through acceptance, a read of both
// partner slots, and the update that also records the first duplicate seen.
// A check word starts a microprogram that scans hospitals in order and,
// for each hospital, its listed students from most preferred up to its own
// partner. Each list entry visited steps through a list read, partner
// read, rank read, compare and advance, and each hospital adds a slot read
// and an advance; the length of a check is set by the single read port
// of the hospital list and the chain of dependent table reads per entry. The
// result word sits in an output register, so the next input word is taken
// while it waits. n_in_use may only be rewritten while the block is idle.
// Partner slots start out unmatched through per-slot valid bits; the list
// and rank tables hold nothing until written and must be loaded before use.
// ----------------------------------------------------------------------------
module stable_matching_checker #(
  parameter int MAX_PARTIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [smc_pkg::ENT_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [smc_pkg::OP_W-1:0]     op,
  input  logic [smc_pkg::ROW_W-1:0]    row,
  input  logic [smc_pkg::POS_W-1:0]    position,
  input  logic [smc_pkg::ENT_W-1:0]    entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [smc_pkg::VAL_W-1:0]    validity,
  output logic [smc_pkg::ENT_W-1:0]    dup_first,
  output logic [smc_pkg::ENT_W-1:0]    dup_second,
  output logic                         stable,
  output logic [smc_pkg::ENT_W-1:0]    blocking_hospital,
  output logic [smc_pkg::ENT_W-1:0]    blocking_student
);
  import smc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTIES);
  localparam int DEPTH = 1 << IDX_W;

  // Sequencer.
  upc_t  upc, upc_next;
  ctrl_t ctrl;
  logic  cond_hit;
  logic  in_acc;

  // Configuration and loaded word fields.
  logic [ENT_W-1:0] n_in_use;
  logic [ENT_W-1:0] n_eff;
  logic [ROW_W-1:0] row_q;
  logic [ENT_W-1:0] ent_q;
  logic             row_ok, pos_ok, ent_ok;

  // Tables. The list and rank tables are indexed by {row, column}.
  logic [ENT_W-1:0] hl_mem [DEPTH*DEPTH];
  logic [POS_W-1:0] rk_mem [DEPTH*DEPTH];
  logic [ENT_W-1:0] hp_mem [DEPTH];
  logic [ENT_W-1:0] sp_mem [DEPTH];
  logic [DEPTH-1:0] hp_vld, sp_vld;

  // Registered read data.
  logic [ENT_W-1:0] hl_q, hp_q, sp_q;
  logic             hp_qv, sp_qv;
  logic [POS_W-1:0] rk_a_q, rk_b_q;
  logic [ENT_W-1:0] hp_eff, sp_eff;

  // Read addresses.
  logic [IDX_W-1:0] h_idx, p_idx, hp_addr, sp_addr, st_idx, cs_idx;

  // Scan state.
  logic [ENT_W-1:0] h_cnt, p_cnt, h_plus;
  logic [ENT_W-1:0] cur_q, st_q, cs_q;
  logic             found;
  logic [ENT_W-1:0] bh_q, bs_q;
  logic             accept;

  // Load bookkeeping and the pending result.
  logic [ENT_W-1:0] pair_count;
  validity_t        dup_kind;
  logic [ENT_W-1:0] dup_a, dup_b;
  validity_t        res_val;
  logic [ENT_W-1:0] res_d1, res_d2;

  // --------------------------------------------------------------------------
  // Input checks and the effective party count. A load with a row, position
  // or entry outside the table is dropped; n_eff is n_in_use clamped to 1..max.
  // --------------------------------------------------------------------------
  assign row_ok = int'(row) < MAX_PARTIES;
  assign pos_ok = int'(position) < MAX_PARTIES;
  assign ent_ok = (entry != '0) && (int'(entry) <= MAX_PARTIES);
  assign in_acc = in_valid && in_ready;

  always_comb begin
    if (n_in_use == '0) begin
      n_eff = ENT_W'(1);
    end else if (int'(n_in_use) > MAX_PARTIES) begin
      n_eff = ENT_W'(MAX_PARTIES);
    end else begin
      n_eff = n_in_use;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: control word lookup, branch conditions and next step.
  // --------------------------------------------------------------------------
  always_comb begin
    ctrl     = ucode(upc);
    in_ready = ctrl.in_rdy;
  end

  assign hp_eff = hp_qv ? hp_q : '0;
  assign sp_eff = sp_qv ? sp_q : '0;
  assign h_plus = h_cnt + ENT_W'(1);

  // The student takes hospital h_plus over the current partner when it is
  // unmatched, or when the hospital ranks strictly better than the partner.
  assign accept = (cs_q != h_plus) &&
                  ((cs_q == '0) || (int'(cs_q) > MAX_PARTIES) || (rk_a_q < rk_b_q));

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_DISPATCH:  cond_hit = 1'b0;
      C_ST_EQ_CUR: cond_hit = (hl_q == cur_q);
      C_ST_BAD:    cond_hit = (st_q == '0) || (int'(st_q) > MAX_PARTIES);
      C_ACCEPT:    cond_hit = accept;
      C_P_MORE:    cond_hit = ((p_cnt + ENT_W'(1)) != n_eff);
      C_H_MORE:    cond_hit = (h_plus != n_eff);
      C_OUT_BUSY:  cond_hit = out_valid && !out_ready;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl.cond == C_DISPATCH) begin
      upc_next = UP_IDLE;
      if (in_valid) begin
        unique case (op_t'(op))
          OP_HLIST, OP_SLIST: upc_next = UP_IDLE;
          OP_PAIR:  upc_next = (row_ok && ent_ok) ? UP_PAIR_RD : UP_IDLE;
          OP_CHECK: upc_next = UP_CHK_INIT;
          default:  upc_next = UP_IDLE;
        endcase
      end
    end else begin
      upc_next = cond_hit ? ctrl.go_true : ctrl.go_false;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // --------------------------------------------------------------------------
  // Table addressing.
  // --------------------------------------------------------------------------
  assign h_idx   = IDX_W'(h_cnt);
  assign p_idx   = IDX_W'(p_cnt);
  assign hp_addr = ctrl.pair_rd ? IDX_W'(row_q) : h_idx;
  assign sp_addr = ctrl.pair_rd ? IDX_W'(ent_q - ENT_W'(1)) : IDX_W'(hl_q - ENT_W'(1));
  assign st_idx  = IDX_W'(st_q - ENT_W'(1));
  assign cs_idx  = IDX_W'(sp_eff - ENT_W'(1));

  // Hospital preference lists: written on load, read during the scan.
  always_ff @(posedge clk) begin
    if (in_acc && (op_t'(op) == OP_HLIST) && row_ok && pos_ok && ent_ok) begin
      hl_mem[{IDX_W'(row), IDX_W'(position)}] <= entry;
    end
    if (ctrl.hl_rd) begin
      hl_q <= hl_mem[{h_idx, p_idx}];
    end
  end

  // Student rank tables: the list position of each hospital for a student.
  always_ff @(posedge clk) begin
    if (in_acc && (op_t'(op) == OP_SLIST) && row_ok && pos_ok && ent_ok) begin
      rk_mem[{IDX_W'(row), IDX_W'(entry - ENT_W'(1))}] <= position;
    end
    if (ctrl.rk_rd) begin
      rk_a_q <= rk_mem[{st_idx, h_idx}];
      rk_b_q <= rk_mem[{st_idx, cs_idx}];
    end
  end

  // Partner slots, one read and one write per cycle each.
  always_ff @(posedge clk) begin
    if (ctrl.pair_wr) begin
      hp_mem[IDX_W'(row_q)]               <= ent_q;
      sp_mem[IDX_W'(ent_q - ENT_W'(1))]   <= ENT_W'(row_q) + ENT_W'(1);
    end
    if (ctrl.pair_rd || ctrl.hp_rd) begin
      hp_q <= hp_mem[hp_addr];
    end
    if (ctrl.pair_rd || ctrl.st_ld) begin
      sp_q <= sp_mem[sp_addr];
    end
  end

  // Slot valid bits make never-written slots read as unmatched.
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_vld <= '0;
      sp_vld <= '0;
      hp_qv  <= 1'b0;
      sp_qv  <= 1'b0;
    end else begin
      if (ctrl.pair_wr) begin
        hp_vld[IDX_W'(row_q)]             <= 1'b1;
        sp_vld[IDX_W'(ent_q - ENT_W'(1))] <= 1'b1;
      end
      if (ctrl.pair_rd || ctrl.hp_rd) begin
        hp_qv <= hp_vld[hp_addr];
      end
      if (ctrl.pair_rd || ctrl.st_ld) begin
        sp_qv <= sp_vld[sp_addr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration, pair bookkeeping and duplicate capture.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_q <= row;
      ent_q <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_in_use   <= N_RESET;
      pair_count <= '0;
      dup_kind   <= VAL_OK;
      dup_a      <= '0;
      dup_b      <= '0;
    end else begin
      if (cfg_we) begin
        n_in_use <= cfg_wdata;
      end
      if (ctrl.pair_wr) begin
        // Only the first duplicate is kept; a hospital clash wins over a
        // student clash on the same pair.
        if (dup_kind == VAL_OK) begin
          if (hp_eff != '0) begin
            dup_kind <= VAL_HOSP_DUP;
            dup_a    <= hp_eff;
            dup_b    <= ent_q;
          end else if (sp_eff != '0) begin
            dup_kind <= VAL_STUD_DUP;
            dup_a    <= sp_eff;
            dup_b    <= ENT_W'(row_q) + ENT_W'(1);
          end
        end
        if (pair_count != ENT_W'(PCNT_MAX)) begin
          pair_count <= pair_count + ENT_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scan datapath.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      h_cnt <= '0;
      p_cnt <= '0;
      found <= 1'b0;
    end else begin
      if (ctrl.chk_init) begin
        h_cnt <= '0;
        found <= 1'b0;
      end
      if (ctrl.hp_rd) begin
        p_cnt <= '0;
      end
      if (ctrl.p_inc) begin
        p_cnt <= p_cnt + ENT_W'(1);
      end
      if (ctrl.h_inc) begin
        h_cnt <= h_plus;
      end
      if (ctrl.mark_found && cond_hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.chk_init) begin
      bh_q <= '0;
      bs_q <= '0;
      // A count mismatch outranks any recorded duplicate.
      if (pair_count != n_in_use) begin
        res_val <= VAL_COUNT;
        res_d1  <= '0;
        res_d2  <= '0;
      end else begin
        res_val <= dup_kind;
        res_d1  <= (dup_kind != VAL_OK) ? dup_a : '0;
        res_d2  <= (dup_kind != VAL_OK) ? dup_b : '0;
      end
    end
    if (ctrl.hl_rd) begin
      cur_q <= hp_eff;
    end
    if (ctrl.st_ld) begin
      st_q <= hl_q;
    end
    if (ctrl.rk_rd) begin
      cs_q <= sp_eff;
    end
    if (ctrl.mark_found && cond_hit) begin
      bh_q <= h_plus;
      bs_q <= st_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. The result word is loaded once the slot is free.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && !cond_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !cond_hit) begin
      validity          <= res_val;
      dup_first         <= res_d1;
      dup_second        <= res_d2;
      stable            <= !found;
      blocking_hospital <= bh_q;
      blocking_student  <= bs_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "stable_matching_checker_defines.svh"

  `SMC_ASSERT_NEXT(a_check_starts, in_acc && (op == OP_CHECK), upc == UP_CHK_INIT, "check word did not start the scan")
  `SMC_ASSERT_NEXT(a_dup_sticky, dup_kind != VAL_OK, dup_kind == $past(dup_kind), "recorded duplicate changed")
  `SMC_ASSERT_NOW(a_count_mono, !$past(rst), pair_count >= $past(pair_count), "pair count went down")
  `SMC_ASSERT_NOW(a_h_in_range, upc == UP_HP_RD, h_cnt < n_eff, "hospital index past the party count")
  `SMC_ASSERT_NOW(a_found_pair, (upc == UP_EMIT) && found, (bh_q != '0) && (bs_q != '0), "blocking pair reported with a zero member")

endmodule
